### hw/rtl/ctsl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctsl_pkg: configuration text style lexer, shared definitions
// Style and continuation codes, run and batch types, and the per-byte
// lexing rules used by the top level.
// ----------------------------------------------------------------------------
package ctsl_pkg;

   localparam int RUN_COUNT_WIDTH = 16;
   localparam int RUN_LEN_W       = 16;
   localparam int STYLE_W         = 4;
   localparam int CHAR_W          = 8;
   localparam int BATCH_MAX       = 5;
   localparam int BATCH_CNT_W     = $clog2(BATCH_MAX + 1);
   localparam int REQ_DATA_W      = ((CHAR_W + 7) / 8) * 8;
   localparam int RSP_DATA_W      = ((STYLE_W + RUN_LEN_W + 7) / 8) * 8;
   localparam int RSP_PAD_W       = RSP_DATA_W - STYLE_W - RUN_LEN_W;

   localparam logic [RUN_COUNT_WIDTH-1:0] RUN_LIMIT = '1;

   // style codes
   localparam logic [STYLE_W-1:0] ST_DEF = 4'd0;
   localparam logic [STYLE_W-1:0] ST_COM = 4'd1;
   localparam logic [STYLE_W-1:0] ST_SEC = 4'd2;
   localparam logic [STYLE_W-1:0] ST_DIR = 4'd3;
   localparam logic [STYLE_W-1:0] ST_ID  = 4'd4;
   localparam logic [STYLE_W-1:0] ST_NUM = 4'd5;
   localparam logic [STYLE_W-1:0] ST_HEX = 4'd6;
   localparam logic [STYLE_W-1:0] ST_STR = 4'd7;
   localparam logic [STYLE_W-1:0] ST_OP  = 4'd8;

   // held byte already consumed by the previous byte's rule
   localparam logic [2:0] SK_NONE     = 3'd0;
   localparam logic [2:0] SK_ESC      = 3'd1;
   localparam logic [2:0] SK_DCOLON   = 3'd2;
   localparam logic [2:0] SK_TAGOPEN  = 3'd3;
   localparam logic [2:0] SK_TAGCLOSE = 3'd4;
   localparam logic [2:0] SK_HEX      = 3'd5;
   localparam logic [2:0] SK_CONT1    = 3'd6;
   localparam logic [2:0] SK_CONT2    = 3'd7;

   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   typedef struct packed {
      logic [STYLE_W-1:0]         lex;
      logic [2:0]                 skip;
      logic                       tag_open;
      logic                       line_start;
      logic                       seen_visible;
      logic [RUN_COUNT_WIDTH-1:0] count;
   } ctx_type;

   typedef struct packed {
      logic                 valid;
      logic [STYLE_W-1:0]   style;
      logic [RUN_LEN_W-1:0] len;
   } run_type;

   typedef struct packed {
      ctx_type ctx;
      logic    taken;
      run_type r0;
      run_type r1;
   } work_type;

   typedef struct packed {
      logic [STYLE_W-1:0]   style;
      logic [RUN_LEN_W-1:0] len;
      logic                 last;
   } entry_type;

   typedef struct packed {
      logic                           load;
      logic [BATCH_CNT_W-1:0]         n;
      entry_type [BATCH_MAX-1:0]      runs;
   } batch_type;

   function automatic logic is_space(logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_digit(logic [CHAR_W-1:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(logic [CHAR_W-1:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_alnum(logic [CHAR_W-1:0] c);
      return is_digit(c) || is_alpha(c);
   endfunction

   function automatic logic is_hex(logic [CHAR_W-1:0] c);
      return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic is_word(logic [CHAR_W-1:0] c);
      return is_alnum(c) || c == "." || c == "_";
   endfunction

   function automatic logic is_eol(logic [CHAR_W-1:0] c);
      return c == CH_CR || c == CH_LF;
   endfunction

   function automatic logic is_unit(logic [CHAR_W-1:0] c);
      return c == "K" || c == "M" || c == "G" || c == "k" || c == "m" || c == "g";
   endfunction

   function automatic logic is_op(logic [CHAR_W-1:0] c);
      return c == "=" || c == ":" || c == ";" || c == "{" || c == "}" || c == "(" ||
             c == ")" || c == "!" || c == "," || c == "|" || c == "*" || c == "$" ||
             c == ".";
   endfunction

   function automatic logic is_delim(logic [CHAR_W-1:0] c);
      return is_space(c) || is_op(c);
   endfunction

   function automatic work_type emit_run(work_type w, logic [STYLE_W-1:0] style,
                                         logic [RUN_LEN_W-1:0] len);
      if (!w.r0.valid) begin
         w.r0.valid = 1'b1;
         w.r0.style = style;
         w.r0.len   = len;
      end else begin
         w.r1.valid = 1'b1;
         w.r1.style = style;
         w.r1.len   = len;
      end
      return w;
   endfunction

   // run ending before the current byte
   function automatic work_type close_before(work_type w, logic [STYLE_W-1:0] style);
      if (w.ctx.count != '0) begin
         w = emit_run(w, style, RUN_LEN_W'(w.ctx.count));
      end
      w.ctx.count = '0;
      return w;
   endfunction

   // run ending with the current byte
   function automatic work_type close_through(work_type w, logic [STYLE_W-1:0] style);
      w = emit_run(w, style, RUN_LEN_W'(w.ctx.count + 1'b1));
      w.ctx.count = '0;
      w.taken     = 1'b1;
      return w;
   endfunction

   function automatic ctx_type line_update(ctx_type s, logic [CHAR_W-1:0] c, logic at_eol);
      if (at_eol) begin
         s.seen_visible = 1'b0;
      end
      if (!s.seen_visible && !is_space(c)) begin
         s.seen_visible = 1'b1;
      end
      return s;
   endfunction

   function automatic work_type tail_rules(work_type w, logic [CHAR_W-1:0] c,
                                           logic [CHAR_W-1:0] n, logic at_eol);
      w.ctx.skip = SK_NONE;
      if (w.ctx.lex != ST_COM && c == "\\" && is_eol(n)) begin
         w.ctx.skip = SK_CONT1;
         return w;
      end
      if (w.ctx.lex == ST_DEF) begin
         if (c == "#") begin
            w = close_before(w, ST_DEF);
            w.ctx.lex = ST_COM;
         end else if (c == "\"") begin
            w = close_before(w, ST_DEF);
            w.ctx.lex = ST_STR;
         end else if (is_op(c)) begin
            w = close_before(w, ST_DEF);
            w.ctx.lex = ST_OP;
         end else if ((!w.ctx.seen_visible && !is_space(c)) || (c == "<" && n == "/")) begin
            w = close_before(w, ST_DEF);
            if (c == "[") begin
               w.ctx.lex = ST_SEC;
            end else begin
               w.ctx.lex      = ST_DIR;
               w.ctx.tag_open = (c == "<");
               if (n == "/") begin
                  w.ctx.skip = SK_TAGOPEN;
                  return w;
               end
            end
         end else if (w.ctx.tag_open &&
                      (c == ">" || ((c == "/" || c == "?") && n == ">"))) begin
            w = close_before(w, ST_DEF);
            if (c == "/" || c == "?") begin
               w.ctx.skip = SK_TAGCLOSE;
               return w;
            end
            w = close_through(w, ST_DIR);
            w.ctx.lex      = ST_DEF;
            w.ctx.tag_open = 1'b0;
         end else if ((c == "+" || c == "-") && is_alnum(n)) begin
            w = close_before(w, ST_DEF);
            w.ctx.lex = ST_OP;
         end else if (is_digit(c)) begin
            w = close_before(w, ST_DEF);
            if (c == "0" && (n == "x" || n == "X")) begin
               w.ctx.lex  = ST_HEX;
               w.ctx.skip = SK_HEX;
               return w;
            end
            w.ctx.lex = ST_NUM;
         end else if (!is_space(c)) begin
            w = close_before(w, ST_DEF);
            w.ctx.lex = ST_ID;
         end
      end
      w.ctx = line_update(w.ctx, c, at_eol);
      return w;
   endfunction

   function automatic work_type full_rules(work_type w, logic [CHAR_W-1:0] c,
                                           logic [CHAR_W-1:0] n);
      logic at_eol;
      at_eol = (c == CH_CR && n != CH_LF) || c == CH_LF;
      case (w.ctx.lex)
         ST_OP: begin
            w = close_before(w, ST_OP);
            w.ctx.lex = ST_DEF;
         end
         ST_NUM: begin
            if (!(is_digit(c) || c == ".")) begin
               if (is_unit(c) && is_delim(n)) begin
                  w = close_through(w, ST_NUM);
                  w.ctx.lex  = ST_DEF;
                  w.ctx.skip = SK_NONE;
                  return w;
               end
               if (is_word(c)) begin
                  w.ctx.lex = ST_ID;
               end else begin
                  w = close_before(w, ST_NUM);
                  w.ctx.lex = ST_DEF;
               end
            end
         end
         ST_HEX: begin
            if (!is_hex(c)) begin
               w = close_before(w, ST_HEX);
               w.ctx.lex = ST_DEF;
            end
         end
         ST_STR: begin
            if (w.ctx.line_start) begin
               w = close_before(w, ST_STR);
               w.ctx.lex = ST_DEF;
            end else if (c == "\\" && (n == "\\" || n == "\"")) begin
               w.ctx.skip = SK_ESC;
               return w;
            end else if (c == "\"") begin
               w = close_through(w, ST_STR);
               w.ctx.lex  = ST_DEF;
               w.ctx.skip = SK_NONE;
               return w;
            end
         end
         ST_DIR: begin
            if (w.ctx.tag_open && c == ":") begin
               w = close_before(w, ST_DIR);
               if (n == ":") begin
                  w.ctx.skip = SK_DCOLON;
                  return w;
               end
               w = close_through(w, ST_OP);
            end else if (is_delim(c) || (w.ctx.tag_open && c == ">")) begin
               w = close_before(w, ST_DIR);
               if (c == ".") begin
                  w = close_through(w, ST_OP);
               end else begin
                  w.ctx.lex = ST_DEF;
               end
            end
         end
         ST_SEC, ST_COM: begin
            if (w.ctx.line_start) begin
               w = close_before(w, w.ctx.lex);
               w.ctx.lex = ST_DEF;
            end
         end
         ST_ID: begin
            if (is_delim(c) || (w.ctx.tag_open && c == ">") || (c == "<" && n == "/")) begin
               w = close_before(w, ST_ID);
               if (c == ".") begin
                  w = close_through(w, ST_OP);
               end else begin
                  w.ctx.lex = ST_DEF;
               end
            end
         end
         default: begin
         end
      endcase
      return tail_rules(w, c, n, at_eol);
   endfunction

   function automatic work_type resume_rules(work_type w, logic [CHAR_W-1:0] c,
                                             logic [CHAR_W-1:0] n);
      case (w.ctx.skip)
         SK_ESC: begin
            w = tail_rules(w, c, n, 1'b0);
         end
         SK_DCOLON: begin
            w = close_through(w, ST_OP);
            w.ctx.lex = ST_DIR;
            w = tail_rules(w, c, n, 1'b0);
         end
         SK_TAGCLOSE: begin
            w = close_through(w, ST_DIR);
            w.ctx.lex      = ST_DEF;
            w.ctx.tag_open = 1'b0;
            w.ctx          = line_update(w.ctx, c, 1'b0);
            w.ctx.skip     = SK_NONE;
         end
         SK_TAGOPEN, SK_HEX: begin
            w.ctx      = line_update(w.ctx, c, 1'b0);
            w.ctx.skip = SK_NONE;
         end
         SK_CONT1: begin
            w.ctx.skip = (c == CH_CR && n == CH_LF) ? SK_CONT2 : SK_NONE;
         end
         default: begin
            w.ctx.skip = SK_NONE;
         end
      endcase
      return w;
   endfunction

   // decide byte c with lookahead n, then count it; gives at most two runs
   function automatic work_type handle_byte(ctx_type s, logic [CHAR_W-1:0] c,
                                            logic [CHAR_W-1:0] n);
      work_type w;
      w.ctx   = s;
      w.taken = 1'b0;
      w.r0    = '0;
      w.r1    = '0;
      if (s.skip == SK_NONE) begin
         w = full_rules(w, c, n);
      end else begin
         w = resume_rules(w, c, n);
      end
      w.ctx.line_start = (c == CH_LF) || (c == CH_CR && n != CH_LF);
      if (!w.taken) begin
         w.ctx.count = w.ctx.count + 1'b1;
         if (w.ctx.count == RUN_LIMIT) begin
            w = emit_run(w, w.ctx.lex, RUN_LEN_W'(w.ctx.count));
            w.ctx.count = '0;
         end
      end
      return w;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/ctsl_run_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctsl_run_queue: result run buffer
// Holds the runs of one lex step and hands them out one transfer per cycle
// while rsp_tready is high; a new batch may load in the cycle the last run leaves.
// ----------------------------------------------------------------------------
module ctsl_run_queue
   import ctsl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire batch_type             batch,
   output logic                       can_load,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // style[3:0], run_length[19:4], zero pad
   output logic                       rsp_tlast
);

   entry_type [BATCH_MAX-1:0] entries_ff, entries_in;
   logic [BATCH_CNT_W-1:0]    count_ff, count_in;
   logic                      drain;

   assign rsp_tvalid = (count_ff != '0);
   assign drain      = rsp_tvalid && rsp_tready;
   assign can_load   = (count_ff == '0) || (count_ff == BATCH_CNT_W'(1) && rsp_tready);
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, entries_ff[0].len, entries_ff[0].style};
   assign rsp_tlast  = entries_ff[0].last;

   always_comb begin
      entries_in = entries_ff;
      count_in   = count_ff;
      if (batch.load) begin
         entries_in = batch.runs;
         count_in   = batch.n;
      end else if (drain) begin
         for (int i = 0; i < BATCH_MAX - 1; i++) begin
            entries_in[i] = entries_ff[i+1];
         end
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
   end

endmodule
`default_nettype wire

### hw/rtl/config_text_style_lexer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// config_text_style_lexer_top: configuration text style lexer
// Bytes of configuration text go in on req_; styled runs (style, length)
// come out on rsp_, covering the text in order. Each byte is decided once
// the next byte arrives; req_tlast ends a text and flushes everything held,
// req_tuser restarts the lexer from the style in csr_wr_data. A byte passes
// an input register, is lexed combinationally and its runs (none up to five)
// are loaded into a run buffer that sends one run per cycle while rsp_tready
// is high. A new byte is lexed only when the run buffer is empty or its last
// run is leaving, so a byte that gives several runs holds back the next byte
// until they are sent. Runs longer than 2^RUN_COUNT_WIDTH-1 bytes are split.
// ----------------------------------------------------------------------------
module config_text_style_lexer_top
   import ctsl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [STYLE_W-1:0]    csr_wr_data,  // initial_style
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,    // character[7:0]
   input  wire logic                  req_tuser,    // start_of_text
   input  wire logic                  req_tlast,    // end_of_text
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,    // style[3:0], run_length[19:4], zero pad
   output logic                       rsp_tlast     // last run of the lex step
);

   logic [STYLE_W-1:0] init_ff;
   logic               in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0]  in_char_ff;
   logic               in_sot_ff;
   logic               in_eot_ff;
   ctx_type            ctx_ff, ctx_in;
   logic [CHAR_W-1:0]  held_ff, held_in;
   logic               held_valid_ff, held_valid_in;

   logic               req_fire;
   logic               proc_fire;
   logic               can_load;
   batch_type          batch;

   assign proc_fire  = in_valid_ff && can_load;
   assign req_tready = !in_valid_ff || proc_fire;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (proc_fire) begin
         in_valid_in = 1'b0;
      end
   end

   // lex step: held byte against the new byte, then the new byte against a
   // space when the text ends
   always_comb begin
      ctx_type  restart_ctx;
      ctx_type  base;
      logic     hv;
      work_type wa;
      work_type wb;
      run_type  fin;
      run_type  cand [BATCH_MAX];
      logic [BATCH_CNT_W-1:0] k;

      restart_ctx.lex          = init_ff;
      restart_ctx.skip         = SK_NONE;
      restart_ctx.tag_open     = 1'b0;
      restart_ctx.line_start   = 1'b1;
      restart_ctx.seen_visible = 1'b0;
      restart_ctx.count        = '0;

      base = in_sot_ff ? restart_ctx : ctx_ff;
      hv   = in_sot_ff ? 1'b0 : held_valid_ff;

      if (hv) begin
         wa = handle_byte(base, held_ff, in_char_ff);
      end else begin
         wa.ctx   = base;
         wa.taken = 1'b0;
         wa.r0    = '0;
         wa.r1    = '0;
      end

      wb = handle_byte(wa.ctx, in_char_ff, CH_SPACE);
      wb.ctx.skip = SK_NONE;
      fin.valid   = (wb.ctx.count != '0);
      fin.style   = wb.ctx.lex;
      fin.len     = RUN_LEN_W'(wb.ctx.count);

      cand[0] = wa.r0;
      cand[1] = wa.r1;
      if (in_eot_ff) begin
         ctx_in        = wb.ctx;
         ctx_in.count  = '0;
         held_in       = '0;
         held_valid_in = 1'b0;
         cand[2]       = wb.r0;
         cand[3]       = wb.r1;
         cand[4]       = fin;
      end else begin
         ctx_in        = wa.ctx;
         held_in       = in_char_ff;
         held_valid_in = 1'b1;
         cand[2]       = '0;
         cand[3]       = '0;
         cand[4]       = '0;
      end

      batch.runs = '0;
      k = '0;
      for (int i = 0; i < BATCH_MAX; i++) begin
         if (cand[i].valid) begin
            batch.runs[k].style = cand[i].style;
            batch.runs[k].len   = cand[i].len;
            k = k + 1'b1;
         end
      end
      if (k != '0) begin
         batch.runs[k - 1'b1].last = 1'b1;
      end
      batch.n    = k;
      batch.load = proc_fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff              <= ST_DEF;
         in_valid_ff          <= 1'b0;
         held_valid_ff        <= 1'b0;
         held_ff              <= '0;
         ctx_ff.lex           <= ST_DEF;
         ctx_ff.skip          <= SK_NONE;
         ctx_ff.tag_open      <= 1'b0;
         ctx_ff.line_start    <= 1'b1;
         ctx_ff.seen_visible  <= 1'b0;
         ctx_ff.count         <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wr_en) begin
            init_ff <= csr_wr_data;
         end
         if (proc_fire) begin
            ctx_ff        <= ctx_in;
            held_ff       <= held_in;
            held_valid_ff <= held_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_char_ff <= req_tdata[CHAR_W-1:0];
         in_sot_ff  <= req_tuser;
         in_eot_ff  <= req_tlast;
      end
   end

   ctsl_run_queue u_run_queue (
      .clock      (clock),
      .reset      (reset),
      .batch      (batch),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // no continuation code survives once no byte is held
   a_skip_clear: assert property (@(posedge clock) disable iff (reset)
      !held_valid_ff |-> ctx_ff.skip == SK_NONE)
      else $error("continuation code left with no held byte");

   // a full-length run is always flushed in the same step
   a_count_below_limit: assert property (@(posedge clock) disable iff (reset)
      ctx_ff.count != RUN_LIMIT)
      else $error("run counter reached its limit");

   a_batch_size: assert property (@(posedge clock) disable iff (reset)
      proc_fire |-> batch.n <= BATCH_CNT_W'(BATCH_MAX))
      else $error("byte produced too many runs");

   a_eot_flush: assert property (@(posedge clock) disable iff (reset)
      proc_fire && in_eot_ff |=> !held_valid_ff && ctx_ff.count == '0)
      else $error("end of text left pending bytes");

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: configuration text style lexer testbench
// Feeds bytes of configuration text through the stream input and predicts
// the styled runs with a behavioural lexer kept in step with every accepted
// transfer. Each run transfer on the output is checked against the oldest
// predicted run. Directed texts come first, then generated configuration
// text with noise under several pacing patterns.
// ----------------------------------------------------------------------------
module tb_top;
   import ctsl_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned SETTLE_CYC   = 8;
   localparam int unsigned SPLIT_LEN    = (1 << RUN_COUNT_WIDTH) - 1;
   localparam int          MAX_STEP_RUN = 6;
   localparam logic [STYLE_W-1:0] STYLE_TOP = '1;

   typedef struct packed {
      logic [STYLE_W-1:0]   style;
      logic [RUN_LEN_W-1:0] len;
      logic                 last;
   } exp_run_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [STYLE_W-1:0]    csr_wr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   config_text_style_lexer_top DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // lexer prediction
   // ---------------------------------------------------------------------
   logic [STYLE_W-1:0] lx_init;
   logic [STYLE_W-1:0] lx_state;
   logic [CHAR_W-1:0]  lx_held;
   bit                 lx_held_ok;
   logic [2:0]         lx_skip;
   bit                 lx_tag;
   bit                 lx_line_start;
   bit                 lx_seen;
   int unsigned        lx_count;
   bit                 byte_taken;
   exp_run_type        step_buf [MAX_STEP_RUN];
   int                 step_n;
   exp_run_type        due_runs [$];

   function automatic bit ch_blank(logic [7:0] c);
      return c == " " || (c >= 8'h09 && c <= 8'h0D);
   endfunction
   function automatic bit ch_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction
   function automatic bit ch_alnum(logic [7:0] c);
      return ch_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction
   function automatic bit ch_hexdig(logic [7:0] c);
      return ch_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction
   function automatic bit ch_word(logic [7:0] c);
      return ch_alnum(c) || c == "." || c == "_";
   endfunction
   function automatic bit ch_eol(logic [7:0] c);
      return c == CH_CR || c == CH_LF;
   endfunction
   function automatic bit ch_unit(logic [7:0] c);
      return c == "K" || c == "M" || c == "G" || c == "k" || c == "m" || c == "g";
   endfunction
   function automatic bit ch_punct(logic [7:0] c);
      return c == "=" || c == ":" || c == ";" || c == "{" || c == "}" || c == "(" ||
             c == ")" || c == "!" || c == "," || c == "|" || c == "*" || c == "$" ||
             c == ".";
   endfunction
   function automatic bit ch_delim(logic [7:0] c);
      return ch_blank(c) || ch_punct(c);
   endfunction

   function automatic void put_run(logic [STYLE_W-1:0] s, int unsigned n);
      if (step_n < MAX_STEP_RUN) begin
         step_buf[step_n].style = s;
         step_buf[step_n].len   = n[RUN_LEN_W-1:0];
         step_buf[step_n].last  = 1'b0;
         step_n++;
      end
   endfunction

   function automatic void end_run_before(logic [STYLE_W-1:0] s);
      if (lx_count > 0) put_run(s, lx_count);
      lx_count = 0;
   endfunction

   function automatic void end_run_with(logic [STYLE_W-1:0] s);
      put_run(s, lx_count + 1);
      lx_count   = 0;
      byte_taken = 1'b1;
   endfunction

   function automatic void track_line(logic [7:0] c, bit eol);
      if (eol) lx_seen = 1'b0;
      if (!lx_seen && !ch_blank(c)) lx_seen = 1'b1;
   endfunction

   // continuation, default-state rules and line bookkeeping
   function automatic logic [2:0] plain_rules(logic [7:0] c, logic [7:0] n, bit eol);
      logic [2:0] nxt;
      nxt = SK_NONE;
      if (lx_state != ST_COM && c == "\\" && ch_eol(n)) begin
         return SK_CONT1;
      end
      if (lx_state == ST_DEF) begin
         if (c == "#") begin
            end_run_before(ST_DEF);
            lx_state = ST_COM;
         end else if (c == "\"") begin
            end_run_before(ST_DEF);
            lx_state = ST_STR;
         end else if (ch_punct(c)) begin
            end_run_before(ST_DEF);
            lx_state = ST_OP;
         end else if ((!lx_seen && !ch_blank(c)) || (c == "<" && n == "/")) begin
            end_run_before(ST_DEF);
            if (c == "[") begin
               lx_state = ST_SEC;
            end else begin
               lx_state = ST_DIR;
               lx_tag   = (c == "<");
               if (n == "/") return SK_TAGOPEN;
            end
         end else if (lx_tag && (c == ">" || ((c == "/" || c == "?") && n == ">"))) begin
            end_run_before(ST_DEF);
            if (c == "/" || c == "?") return SK_TAGCLOSE;
            end_run_with(ST_DIR);
            lx_state = ST_DEF;
            lx_tag   = 1'b0;
         end else if ((c == "+" || c == "-") && ch_alnum(n)) begin
            end_run_before(ST_DEF);
            lx_state = ST_OP;
         end else if (ch_digit(c)) begin
            end_run_before(ST_DEF);
            if (c == "0" && (n == "x" || n == "X")) begin
               lx_state = ST_HEX;
               return SK_HEX;
            end
            lx_state = ST_NUM;
         end else if (!ch_blank(c)) begin
            end_run_before(ST_DEF);
            lx_state = ST_ID;
         end
      end
      track_line(c, eol);
      return nxt;
   endfunction

   function automatic logic [2:0] style_rules(logic [7:0] c, logic [7:0] n);
      bit eol;
      eol = (c == CH_CR && n != CH_LF) || c == CH_LF;
      case (lx_state)
         ST_OP: begin
            end_run_before(ST_OP);
            lx_state = ST_DEF;
         end
         ST_NUM: begin
            if (!(ch_digit(c) || c == ".")) begin
               // unit suffix closes the number with itself
               if (ch_unit(c) && ch_delim(n)) begin
                  end_run_with(ST_NUM);
                  lx_state = ST_DEF;
                  return SK_NONE;
               end
               if (ch_word(c)) begin
                  lx_state = ST_ID;
               end else begin
                  end_run_before(ST_NUM);
                  lx_state = ST_DEF;
               end
            end
         end
         ST_HEX: begin
            if (!ch_hexdig(c)) begin
               end_run_before(ST_HEX);
               lx_state = ST_DEF;
            end
         end
         ST_STR: begin
            if (lx_line_start) begin
               end_run_before(ST_STR);
               lx_state = ST_DEF;
            end else if (c == "\\" && (n == "\\" || n == "\"")) begin
               return SK_ESC;
            end else if (c == "\"") begin
               end_run_with(ST_STR);
               lx_state = ST_DEF;
               return SK_NONE;
            end
         end
         ST_DIR: begin
            if (lx_tag && c == ":") begin
               end_run_before(ST_DIR);
               if (n == ":") return SK_DCOLON;
               end_run_with(ST_OP);
            end else if (ch_delim(c) || (lx_tag && c == ">")) begin
               end_run_before(ST_DIR);
               if (c == ".") end_run_with(ST_OP);
               else lx_state = ST_DEF;
            end
         end
         ST_SEC, ST_COM: begin
            if (lx_line_start) begin
               end_run_before(lx_state);
               lx_state = ST_DEF;
            end
         end
         ST_ID: begin
            if (ch_delim(c) || (lx_tag && c == ">") || (c == "<" && n == "/")) begin
               end_run_before(ST_ID);
               if (c == ".") end_run_with(ST_OP);
               else lx_state = ST_DEF;
            end
         end
         default: begin
         end
      endcase
      return plain_rules(c, n, eol);
   endfunction

   // second byte of a two-byte rule
   function automatic logic [2:0] skip_rules(logic [7:0] c, logic [7:0] n);
      logic [2:0] nxt;
      nxt = SK_NONE;
      case (lx_skip)
         SK_ESC: nxt = plain_rules(c, n, 1'b0);
         SK_DCOLON: begin
            end_run_with(ST_OP);
            lx_state = ST_DIR;
            nxt = plain_rules(c, n, 1'b0);
         end
         SK_TAGCLOSE: begin
            end_run_with(ST_DIR);
            lx_state = ST_DEF;
            lx_tag   = 1'b0;
            track_line(c, 1'b0);
         end
         SK_TAGOPEN, SK_HEX: track_line(c, 1'b0);
         SK_CONT1: nxt = (c == CH_CR && n == CH_LF) ? SK_CONT2 : SK_NONE;
         default: nxt = SK_NONE;
      endcase
      return nxt;
   endfunction

   function automatic void decide_byte(logic [7:0] c, logic [7:0] n);
      logic [2:0] nxt;
      byte_taken = 1'b0;
      if (lx_skip == SK_NONE) nxt = style_rules(c, n);
      else nxt = skip_rules(c, n);
      lx_skip       = nxt;
      lx_line_start = (c == CH_LF) || (c == CH_CR && n != CH_LF);
      if (!byte_taken) begin
         lx_count++;
         if (lx_count >= SPLIT_LEN) begin
            put_run(lx_state, lx_count);
            lx_count = 0;
         end
      end
   endfunction

   function automatic void restart_text();
      lx_state      = lx_init;
      lx_held       = '0;
      lx_held_ok    = 1'b0;
      lx_skip       = SK_NONE;
      lx_tag        = 1'b0;
      lx_line_start = 1'b1;
      lx_seen       = 1'b0;
      lx_count      = 0;
   endfunction

   function automatic void predict_byte(logic [7:0] b, bit sot, bit eot);
      step_n = 0;
      if (sot) restart_text();
      if (lx_held_ok) decide_byte(lx_held, b);
      lx_held    = b;
      lx_held_ok = 1'b1;
      if (eot) begin
         // lookahead past the end reads as a space
         decide_byte(b, CH_SPACE);
         lx_skip = SK_NONE;
         end_run_before(lx_state);
         lx_held_ok = 1'b0;
         lx_held    = '0;
      end
      if (step_n > 0) step_buf[step_n - 1].last = 1'b1;
      for (int i = 0; i < step_n; i++) due_runs.push_back(step_buf[i]);
   endfunction

   // ---------------------------------------------------------------------
   // pacing, checking, timeout
   // ---------------------------------------------------------------------
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned mismatches;
   int unsigned cycle_count;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      exp_run_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_runs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected run: style %0d len %0d last %0b",
                        rsp_tdata[STYLE_W-1:0], rsp_tdata[STYLE_W+RUN_LEN_W-1:STYLE_W],
                        rsp_tlast);
         end else begin
            want = due_runs.pop_front();
            if (rsp_tdata[STYLE_W-1:0] !== want.style ||
                rsp_tdata[STYLE_W+RUN_LEN_W-1:STYLE_W] !== want.len ||
                rsp_tlast !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("run mismatch: want style %0d len %0d last %0b, got %0d %0d %0b",
                           want.style, want.len, want.last, rsp_tdata[STYLE_W-1:0],
                           rsp_tdata[STYLE_W+RUN_LEN_W-1:STYLE_W], rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers; all entered and left just after a falling edge
   // ---------------------------------------------------------------------
   logic [7:0] text_buf [$];
   string word_set = "aAbfgkmxzKMG_059";
   string op_set   = "=:;{}()!,|*$.";
   string hex_set  = "0123456789abcdefABCDEFgx";
   string unit_set = "KMGkmg";
   string sep_set  = " ,;)\n\t";

   task automatic send_byte(input logic [7:0] ch, input bit sot, input bit eot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= sot;
      req_tlast  <= eot;
      do @(posedge clock); while (!req_tready);
      predict_byte(ch, sot, eot);
      @(negedge clock);
   endtask

   task automatic send_text(input string s, input bit sot, input bit eot);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], sot && i == 0, eot && i == s.len() - 1);
   endtask

   // hold off until every predicted run has been seen
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (due_runs.size() != 0);
   endtask

   // a held byte may still be in flight even with nothing predicted
   task automatic settle();
      drain();
      repeat (SETTLE_CYC) @(negedge clock);
   endtask

   task automatic write_style(input logic [STYLE_W-1:0] v);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      lx_init = v;
   endtask

   task automatic set_pace(input int unsigned send_pct, input int unsigned recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   function automatic logic [7:0] pick_from(input string s);
      return s[$urandom_range(s.len() - 1)];
   endfunction

   task automatic add_str(input string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endtask

   task automatic add_from(input string s, input int unsigned maxlen);
      int unsigned k;
      k = $urandom_range(maxlen, 1);
      repeat (k) text_buf.push_back(pick_from(s));
   endtask

   task automatic add_eol();
      case ($urandom_range(2))
         0: add_str("\n");
         1: add_str("\r\n");
         default: add_str("\r");
      endcase
   endtask

   // one token of plausible configuration text, or a little noise
   task automatic add_token();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 8) begin
         add_str("#");
         add_from(word_set, 6);
         add_eol();
      end else if (pick < 14) begin
         add_str("[");
         add_from(word_set, 5);
         add_str("]");
         add_eol();
      end else if (pick < 22) begin
         add_from(word_set, 5);
         add_str(pick[0] ? " = " : "=");
         add_from(word_set, 4);
         add_eol();
      end else if (pick < 28) begin
         add_str("<");
         add_from(word_set, 4);
         if ($urandom_range(1)) begin
            add_str(" ");
            add_from(word_set, 3);
            add_str("=\"");
            add_from(word_set, 3);
            add_str("\"");
         end
         add_str(">");
      end else if (pick < 32) begin
         add_str("</");
         add_from(word_set, 4);
         add_str(">");
      end else if (pick < 36) begin
         add_str($urandom_range(1) ? "<" : "<?");
         add_from(word_set, 4);
         add_str($urandom_range(1) ? "/>" : "?>");
      end else if (pick < 40) begin
         add_str("<");
         add_from(word_set, 3);
         add_str($urandom_range(1) ? "::" : ":");
         add_from(word_set, 3);
         add_str(">");
      end else if (pick < 50) begin
         add_from("0123456789.", 4);
         if ($urandom_range(1)) text_buf.push_back(pick_from(unit_set));
         text_buf.push_back(pick_from(sep_set));
      end else if (pick < 56) begin
         add_str($urandom_range(1) ? "0x" : "0X");
         add_from(hex_set, 4);
         text_buf.push_back(pick_from(sep_set));
      end else if (pick < 64) begin
         add_str("\"");
         repeat ($urandom_range(5)) begin
            case ($urandom_range(3))
               0: add_str("\\\"");
               1: add_str("\\\\");
               default: text_buf.push_back(pick_from(word_set));
            endcase
         end
         // an unterminated string ends at the line end
         if ($urandom_range(4) != 0) add_str("\"");
         else add_eol();
      end else if (pick < 72) begin
         if ($urandom_range(2) == 0) begin
            add_str($urandom_range(1) ? "+" : "-");
            add_from(word_set, 3);
         end else begin
            text_buf.push_back(pick_from(op_set));
         end
      end else if (pick < 76) begin
         add_str("\\");
         add_eol();
         add_from(word_set, 3);
      end else if (pick < 88) begin
         case ($urandom_range(4))
            0: add_str(" ");
            1: add_str("\t");
            2: text_buf.push_back(8'h0B);
            3: text_buf.push_back(8'h0C);
            default: add_eol();
         endcase
      end else begin
         repeat ($urandom_range(3, 1)) text_buf.push_back(8'($urandom_range(255)));
      end
   endtask

   task automatic run_random_texts(input int unsigned items, input bit with_pause);
      int unsigned sent;
      bit          paused;
      bit          sot;
      bit          eot;
      sent   = 0;
      paused = 1'b0;
      while (sent < items) begin
         text_buf.delete();
         repeat ($urandom_range(8, 2)) add_token();
         foreach (text_buf[i]) begin
            // mostly framed texts; now and then a missing or stray boundary
            if (i == 0) sot = ($urandom_range(19) != 0);
            else sot = ($urandom_range(49) == 0);
            if (i == text_buf.size() - 1) eot = ($urandom_range(19) != 0);
            else eot = ($urandom_range(49) == 0);
            send_byte(text_buf[i], sot, eot);
         end
         sent += text_buf.size();
         if (with_pause && !paused && sent >= items / 2) begin
            drain();
            paused = 1'b1;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   task automatic test_directed();
      set_pace(0, 0);
      write_style(ST_DEF);
      send_byte(8'h00, 1'b1, 1'b1);
      send_byte(8'hFF, 1'b1, 1'b1);
      send_text("<a::b/>", 1'b1, 1'b1);
      send_text("x 0x1f 5K", 1'b1, 1'b1);
      // restart while a byte is held drops it and its open run
      send_text("ab", 1'b1, 1'b0);
      send_text("\"q", 1'b1, 1'b1);
      // no start after an end: carries on from the state left behind
      send_byte("1", 1'b0, 1'b1);
   endtask

   task automatic test_unknown_style();
      set_pace(0, 0);
      write_style(STYLE_TOP);
      send_text("a", 1'b1, 1'b0);
      // new setting only applies from the next text start
      write_style(ST_ID);
      send_text("b\\\nc", 1'b0, 1'b1);
      send_text("k=1", 1'b1, 1'b1);
   endtask

   task automatic test_random_steady();
      set_pace(0, 0);
      write_style(ST_DEF);
      run_random_texts(80, 1'b0);
   endtask

   task automatic test_random_sender_gaps();
      set_pace(53, 0);
      write_style(ST_OP);
      run_random_texts(80, 1'b0);
   endtask

   task automatic test_random_receiver_stalls();
      set_pace(0, 53);
      write_style(STYLE_W'($urandom_range(8)));
      run_random_texts(80, 1'b1);
   endtask

   task automatic test_random_both();
      set_pace(24, 24);
      write_style(STYLE_W'($urandom_range(15)));
      run_random_texts(80, 1'b0);
   endtask

   initial begin
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      req_tlast   = 1'b0;
      rsp_tready  = 1'b0;
      mismatches  = 0;
      cycle_count = 0;
      set_pace(0, 0);
      lx_init = ST_DEF;
      restart_text();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_unknown_style();
      test_random_steady();
      test_random_sender_gaps();
      test_random_receiver_stalls();
      test_random_both();

      settle();
      repeat (SETTLE_CYC) @(negedge clock);
      if (mismatches == 0 && due_runs.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
